// ----- rtl/sscr_pkg.sv -----
// ----------------------------------------------------------------------------
// sscr_pkg
// Shared types and constants of the speed-scaled collision risk block.
// ----------------------------------------------------------------------------
package sscr_pkg;

   // Field widths.
   localparam int unsigned ID_WIDTH    = 11;
   localparam int unsigned LEN_WIDTH   = 4;
   localparam int unsigned BYTE_WIDTH  = 8;
   localparam int unsigned SPEED_WIDTH = 16;
   localparam int unsigned DIST_WIDTH  = 16;
   localparam int unsigned CSR_WIDTH   = 16;
   localparam int unsigned CSR_IDX_WIDTH = 2;

   // Speed clamp window in mm/s and the offset width above its floor.
   localparam logic [SPEED_WIDTH-1:0] SPEED_LOW_MMS  = 16'd800;
   localparam logic [SPEED_WIDTH-1:0] SPEED_HIGH_MMS = 16'd2500;
   localparam int unsigned OFFSET_WIDTH = 11;

   // Threshold numerators over the common denominator SCALE_DEN.
   localparam int unsigned SCALE_DEN   = 340;
   localparam int unsigned EMERG_BASE  = 6800;
   localparam int unsigned EMERG_SLOPE = 11;
   localparam int unsigned WARN_BASE   = 13600;
   localparam int unsigned WARN_SLOPE  = 22;
   localparam int unsigned THR_WIDTH   = 16;
   localparam int unsigned LHS_WIDTH   = 25;

   // Minimum frame length that carries a full distance.
   localparam logic [LEN_WIDTH-1:0] LEN_FULL = 4'd2;
   localparam logic [LEN_WIDTH-1:0] LEN_ONE  = 4'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FRAME_ID_FIRST  = 2'd0,
      CSR_FRAME_ID_SECOND = 2'd1,
      CSR_FRAME_ID_THIRD  = 2'd2,
      CSR_MAX_DISTANCE    = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_FRAME  = 1'b0,
      CMD_UPDATE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      RISK_SAFE  = 2'd0,
      RISK_WARN  = 2'd1,
      RISK_EMERG = 2'd2
   } risk_type;

   typedef struct packed {
      cmd_type                command;
      logic [ID_WIDTH-1:0]    frame_id;
      logic [LEN_WIDTH-1:0]   frame_length;
      logic [BYTE_WIDTH-1:0]  data_low;
      logic [BYTE_WIDTH-1:0]  data_high;
      logic [SPEED_WIDTH-1:0] speed_mms;
   } req_payload_type;

   typedef struct packed {
      risk_type              risk;
      logic                  brake_on;
      logic                  brake_toggled;
      logic                  fresh;
      logic [DIST_WIDTH-1:0] distance_used;
   } rsp_payload_type;

endpackage

// ----- rtl/speed_scaled_collision_risk.sv -----
// ----------------------------------------------------------------------------
// speed_scaled_collision_risk
// Latches distance frames by CAN identifier and grades collision risk on
// each speed update.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_payload) carries two kinds
// of request. A frame request whose identifier matches one of the three
// configured identifiers latches its first two data bytes and length; it
// gives no response. An update request consumes a pending frame, grades
// the distance against limits that grow with the clamped speed and gives
// one response on rsp_valid, rsp_stall, rsp_payload.
// A request is registered in the input register when it is accepted; an
// update's response is then registered in the output register as the update
// moves on. One request is accepted per cycle while req_stall is low.
// When the receiver stalls, the response waits in the output register while
// one more request is held in the input register; a frame request still
// moves on, an update request waits for the output register to free up.
// Synchronous reset clears the latched frame, distance, risk and brake state
// and the configuration registers (maximum distance to 65535); the block
// accepts requests in the first cycle after reset.
// Configuration is written through csr_write_enable, csr_index and
// csr_write_data while no request is in flight.
// ----------------------------------------------------------------------------
module speed_scaled_collision_risk import sscr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]  csr_write_data
);

   // Configuration registers.
   logic [ID_WIDTH-1:0]   id_first_ff;
   logic [ID_WIDTH-1:0]   id_second_ff;
   logic [ID_WIDTH-1:0]   id_third_ff;
   logic [DIST_WIDTH-1:0] max_dist_ff;

   // Input register.
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // Block state.
   logic [BYTE_WIDTH-1:0] held_low_ff,  held_low_in;
   logic [BYTE_WIDTH-1:0] held_high_ff, held_high_in;
   logic [LEN_WIDTH-1:0]  held_len_ff,  held_len_in;
   logic                  pending_ff,   pending_in;
   logic [DIST_WIDTH-1:0] dist_ff,      dist_in;
   risk_type              last_risk_ff, last_risk_in;
   logic                  brake_ff,     brake_in;

   // Output register.
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_data_ff,  out_data_in;

   logic      advance;
   logic      is_update;
   logic      id_match;
   risk_type  risk_new;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_first_ff  <= '0;
         id_second_ff <= '0;
         id_third_ff  <= '0;
         max_dist_ff  <= '1;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_ID_FIRST:  id_first_ff  <= csr_write_data[ID_WIDTH-1:0];
            CSR_FRAME_ID_SECOND: id_second_ff <= csr_write_data[ID_WIDTH-1:0];
            CSR_FRAME_ID_THIRD:  id_third_ff  <= csr_write_data[ID_WIDTH-1:0];
            CSR_MAX_DISTANCE:    max_dist_ff  <= csr_write_data[DIST_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The held request moves on unless it is an update facing a full,
   // stalled output register.
   assign is_update = (in_data_ff.command == CMD_UPDATE);
   assign advance   = in_valid_ff && (!is_update || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign in_valid_in = req_valid || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_payload;
      end
   end

   assign id_match = (in_data_ff.frame_id == id_first_ff) ||
                     (in_data_ff.frame_id == id_second_ff) ||
                     (in_data_ff.frame_id == id_third_ff);

   // Distance seen by an update: a pending full-length frame replaces it.
   always_comb begin
      dist_in = dist_ff;
      if (pending_ff && (held_len_ff >= LEN_FULL)) begin
         dist_in = {held_high_ff, held_low_ff};
      end
   end

   sscr_assess u_assess (
      .distance     (dist_in),
      .speed_mms    (in_data_ff.speed_mms),
      .max_distance (max_dist_ff),
      .risk         (risk_new)
   );

   // Next state and response for the request that moves on.
   always_comb begin
      held_low_in  = held_low_ff;
      held_high_in = held_high_ff;
      held_len_in  = held_len_ff;
      pending_in   = pending_ff;
      last_risk_in = last_risk_ff;
      brake_in     = brake_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (advance) begin
         if (!is_update) begin
            if (id_match) begin
               if (in_data_ff.frame_length >= LEN_ONE) begin
                  held_low_in = in_data_ff.data_low;
               end
               if (in_data_ff.frame_length >= LEN_FULL) begin
                  held_high_in = in_data_ff.data_high;
               end
               held_len_in = in_data_ff.frame_length;
               pending_in  = 1'b1;
            end
         end else begin
            pending_in                = 1'b0;
            last_risk_in              = risk_new;
            brake_in                  = (risk_new == RISK_EMERG);
            out_valid_in              = 1'b1;
            out_data_in.risk          = risk_new;
            out_data_in.brake_on      = (risk_new == RISK_EMERG);
            out_data_in.brake_toggled = ((risk_new == RISK_EMERG) != brake_ff);
            out_data_in.fresh         = pending_ff || (risk_new != last_risk_ff);
            out_data_in.distance_used = dist_in;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_low_ff  <= '0;
         held_high_ff <= '0;
         held_len_ff  <= '0;
         pending_ff   <= 1'b0;
         dist_ff      <= '0;
         last_risk_ff <= RISK_SAFE;
         brake_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_low_ff  <= held_low_in;
         held_high_ff <= held_high_in;
         held_len_ff  <= held_len_in;
         pending_ff   <= pending_in;
         if (advance && is_update) begin
            dist_ff <= dist_in;
         end
         last_risk_ff <= last_risk_in;
         brake_ff     <= brake_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // The brake level always follows the last graded risk.
   a_brake_follows_risk: assert property (@(posedge clock) disable iff (reset)
      brake_ff == (last_risk_ff == RISK_EMERG))
      else $error("brake state differs from last risk");

   // A shown response with the brake on is an emergency.
   a_brake_is_emergency: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.brake_on) |-> (rsp_payload.risk == RISK_EMERG))
      else $error("brake on without emergency risk");

   // An update never overtakes a response the receiver has not taken.
   a_update_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && is_update && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("update advanced into a stalled output register");

   // No response is shown in the cycle after reset.
   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ----- rtl/sscr_assess.sv -----
// ----------------------------------------------------------------------------
// sscr_assess
// Combinational risk grading of one distance against speed-scaled limits.
// ----------------------------------------------------------------------------
module sscr_assess import sscr_pkg::*; (
   input  logic [DIST_WIDTH-1:0]  distance,
   input  logic [SPEED_WIDTH-1:0] speed_mms,
   input  logic [DIST_WIDTH-1:0]  max_distance,
   output risk_type               risk
);

   logic [SPEED_WIDTH-1:0]  speed_clamped;
   logic [OFFSET_WIDTH-1:0] offset;
   logic [THR_WIDTH-1:0]    emerg_thr;
   logic [THR_WIDTH-1:0]    warn_thr;
   logic [LHS_WIDTH-1:0]    lhs;
   logic                    out_of_range;

   // Clamp the speed into the working window and take its offset.
   always_comb begin
      priority if (speed_mms < SPEED_LOW_MMS) begin
         speed_clamped = SPEED_LOW_MMS;
      end else if (speed_mms > SPEED_HIGH_MMS) begin
         speed_clamped = SPEED_HIGH_MMS;
      end else begin
         speed_clamped = speed_mms;
      end
   end

   assign offset = OFFSET_WIDTH'(speed_clamped - SPEED_LOW_MMS);

   // Threshold numerators; the slopes are small constant multiplies.
   assign emerg_thr = THR_WIDTH'(EMERG_BASE) +
                      THR_WIDTH'(EMERG_SLOPE) * THR_WIDTH'(offset);
   assign warn_thr  = THR_WIDTH'(WARN_BASE) +
                      THR_WIDTH'(WARN_SLOPE) * THR_WIDTH'(offset);

   // Distance scaled by the common denominator.
   assign lhs = LHS_WIDTH'(SCALE_DEN) * LHS_WIDTH'(distance);

   assign out_of_range = (distance == '0) || (distance > max_distance);

   // Grade the reading; emergency has priority over warning.
   always_comb begin
      priority if (out_of_range) begin
         risk = RISK_SAFE;
      end else if (lhs < LHS_WIDTH'(emerg_thr)) begin
         risk = RISK_EMERG;
      end else if (lhs < LHS_WIDTH'(warn_thr)) begin
         risk = RISK_WARN;
      end else begin
         risk = RISK_SAFE;
      end
   end

endmodule
